/* rtl/core/tccs_pkg.sv */
// shared types, constants and codes for the text console engine
`timescale 1ns / 1ps

package tccs_pkg;

    // field widths
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // default geometry of the cell store
    localparam int DEF_MAX_ROWS = 25;
    localparam int DEF_MAX_COLS = 80;

    // item kinds
    localparam logic [KIND_W-1:0] K_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] K_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] K_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd2;

    // register reset values
    localparam logic [ROW_W-1:0]  RST_ROWS = 5'd25;
    localparam logic [COL_W-1:0]  RST_COLS = 7'd80;
    localparam logic [ATTR_W-1:0] RST_ATTR = 8'd7;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

    // effective geometry and attribute handed to the engine
    typedef struct packed {
        logic [ROW_W-1:0]  rows;
        logic [COL_W-1:0]  cols;
        logic [ATTR_W-1:0] attr;
    } tccs_geom_t;

    // cell memory strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tccs_ram_ctl_t;

endpackage

/* rtl/core/tccs_cell_ram.sv */
// single port cell memory with registered read data
`timescale 1ns / 1ps

module tccs_cell_ram
    import tccs_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
    parameter int AW    = 11
)
(
    input  logic              clk,
    input  tccs_ram_ctl_t     ctl,
    input  logic [AW-1:0]     addr,
    input  logic [CELL_W-1:0] wr_data,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

/* rtl/core/tccs_engine.sv */
// sequencer: cursor, cell writes, clear and scroll walks, reads, result register
`timescale 1ns / 1ps

module tccs_engine
    import tccs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int AW       = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tccs_geom_t        geom,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    input  logic              end_of_write,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CELL_W-1:0] cell_value,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic              scrolled,
    output logic              write_done,
    output tccs_ram_ctl_t     ram_ctl,
    output logic [AW-1:0]     ram_addr,
    output logic [CELL_W-1:0] ram_wdata,
    input  logic [CELL_W-1:0] ram_rdata
);

    localparam int WROW_W = ($clog2(MAX_ROWS) > ROW_W) ? $clog2(MAX_ROWS) : ROW_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHAR,
        S_CLR,
        S_SCR_RD,
        S_SCR_WR,
        S_RD,
        S_RD_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [ROW_W-1:0]  rrow_reg, rrow_next;
    logic [COL_W-1:0]  rcol_reg, rcol_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [WROW_W-1:0] wk_row_reg, wk_row_next;
    logic [COL_W-1:0]  wk_col_reg, wk_col_next;
    logic [CELL_W-1:0] res_value_reg, res_value_next;
    logic              res_scr_reg, res_scr_next;
    logic              res_done_reg, res_done_next;
    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_value_reg, out_value_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic              out_scr_reg, out_scr_next;
    logic              out_done_reg, out_done_next;

    logic [ROW_W-1:0]  rows;
    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  row_sat;
    logic [COL_W-1:0]  col_sat;
    logic [COL_W-1:0]  col_inc;
    logic [31:0]       lim_r;
    logic [31:0]       lim_c;
    logic              last_col;
    logic              last_row;
    logic [WROW_W-1:0] step_row;
    logic [COL_W-1:0]  step_col;
    logic [WROW_W-1:0] arow;
    logic [COL_W-1:0]  acol;
    logic [31:0]       addr_full;
    logic              go_done;
    logic              take_nl;
    logic              finish_ok;
    logic              rd_in_range;

    assign rows = geom.rows;
    assign cols = geom.cols;

    // cursor clamped into the visible area before a character
    assign row_sat = (cur_row_reg >= rows) ? rows - 1'b1 : cur_row_reg;
    assign col_sat = (cur_col_reg >= cols) ? cols - 1'b1 : cur_col_reg;
    assign col_inc = col_sat + 1'b1;

    // walk limits: whole store during the power-up clear, visible area otherwise
    assign lim_r    = (state_reg == S_INIT) ? 32'(MAX_ROWS) : 32'(rows);
    assign lim_c    = (state_reg == S_INIT) ? 32'(MAX_COLS) : 32'(cols);
    assign last_col = (32'(wk_col_reg) + 32'd1) == lim_c;
    assign last_row = (32'(wk_row_reg) + 32'd1) == lim_r;
    assign step_row = last_col ? wk_row_reg + 1'b1 : wk_row_reg;
    assign step_col = last_col ? '0 : wk_col_reg + 1'b1;

    // shared address unit
    assign addr_full = 32'(arow) * 32'(MAX_COLS) + 32'(acol);
    assign ram_addr  = addr_full[AW-1:0];

    assign rd_in_range = (32'(read_row) < 32'(MAX_ROWS)) && (32'(read_col) < 32'(MAX_COLS));
    assign finish_ok   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ch_next        = ch_reg;
        rrow_next      = rrow_reg;
        rcol_next      = rcol_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        wk_row_next    = wk_row_reg;
        wk_col_next    = wk_col_reg;
        res_value_next = res_value_reg;
        res_scr_next   = res_scr_reg;
        res_done_next  = res_done_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_scr_next   = out_scr_reg;
        out_done_next  = out_done_reg;
        ram_ctl        = '0;
        ram_wdata      = '0;
        arow           = '0;
        acol           = '0;
        go_done        = 1'b0;
        take_nl        = 1'b0;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_ctl.wr_en = 1'b1;
                arow          = wk_row_reg;
                acol          = wk_col_reg;
                wk_row_next   = step_row;
                wk_col_next   = step_col;
                if (last_col && last_row)
                begin
                    wk_row_next = '0;
                    wk_col_next = '0;
                    state_next  = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    ch_next        = char_code;
                    rrow_next      = read_row;
                    rcol_next      = read_col;
                    res_value_next = '0;
                    res_scr_next   = 1'b0;
                    res_done_next  = (kind == K_CHAR) ? end_of_write : 1'b0;
                    case (kind)
                        K_CHAR:
                        begin
                            state_next = S_CHAR;
                        end
                        K_CLEAR:
                        begin
                            wk_row_next = '0;
                            wk_col_next = '0;
                            state_next  = S_CLR;
                        end
                        K_READ:
                        begin
                            state_next = rd_in_range ? S_RD : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_CHAR:
            begin
                if (ch_reg == CH_NEWLINE)
                begin
                    take_nl = 1'b1;
                end
                else
                begin
                    ram_ctl.wr_en = 1'b1;
                    arow          = WROW_W'(row_sat);
                    acol          = col_sat;
                    ram_wdata     = {geom.attr, ch_reg};
                    if (col_inc >= cols)
                    begin
                        take_nl = 1'b1;
                    end
                    else
                    begin
                        cur_row_next = row_sat;
                        cur_col_next = col_inc;
                        go_done      = 1'b1;
                    end
                end
                if (take_nl)
                begin
                    cur_col_next = '0;
                    if (row_sat >= rows - 1'b1)
                    begin
                        // bottom row: stay there and move the screen up
                        cur_row_next = rows - 1'b1;
                        res_scr_next = 1'b1;
                        if (rows > 5'd1)
                        begin
                            wk_row_next = WROW_W'(1);
                            wk_col_next = '0;
                            state_next  = S_SCR_RD;
                        end
                        else
                        begin
                            go_done = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_row_next = row_sat + 1'b1;
                        go_done      = 1'b1;
                    end
                end
            end

            S_CLR:
            begin
                ram_ctl.wr_en = 1'b1;
                arow          = wk_row_reg;
                acol          = wk_col_reg;
                ram_wdata     = {geom.attr, CH_BLANK};
                wk_row_next   = step_row;
                wk_col_next   = step_col;
                if (last_col && last_row)
                begin
                    go_done = 1'b1;
                end
            end

            S_SCR_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                arow          = wk_row_reg;
                acol          = wk_col_reg;
                state_next    = S_SCR_WR;
            end

            S_SCR_WR:
            begin
                // copy the cell one row up
                ram_ctl.wr_en = 1'b1;
                arow          = wk_row_reg - 1'b1;
                acol          = wk_col_reg;
                ram_wdata     = ram_rdata;
                wk_row_next   = step_row;
                wk_col_next   = step_col;
                if (last_col && last_row)
                begin
                    go_done = 1'b1;
                end
                else
                begin
                    state_next = S_SCR_RD;
                end
            end

            S_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                arow          = WROW_W'(rrow_reg);
                acol          = rcol_reg;
                state_next    = S_RD_WAIT;
            end

            S_RD_WAIT:
            begin
                res_value_next = ram_rdata;
                go_done        = 1'b1;
            end

            S_DONE:
            begin
                go_done = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register once it is free
        if (go_done)
        begin
            if (finish_ok)
            begin
                out_valid_next = 1'b1;
                out_value_next = res_value_next;
                out_row_next   = cur_row_next;
                out_col_next   = cur_col_next;
                out_scr_next   = res_scr_next;
                out_done_next  = res_done_next;
                state_next     = S_IDLE;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            kind_reg      <= '0;
            ch_reg        <= '0;
            rrow_reg      <= '0;
            rcol_reg      <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            wk_row_reg    <= '0;
            wk_col_reg    <= '0;
            res_value_reg <= '0;
            res_scr_reg   <= 1'b0;
            res_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_scr_reg   <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            ch_reg        <= ch_next;
            rrow_reg      <= rrow_next;
            rcol_reg      <= rcol_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            wk_row_reg    <= wk_row_next;
            wk_col_reg    <= wk_col_next;
            res_value_reg <= res_value_next;
            res_scr_reg   <= res_scr_next;
            res_done_reg  <= res_done_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_scr_reg   <= out_scr_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = out_value_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign scrolled   = out_scr_reg;
    assign write_done = out_done_reg;

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while a previous item is in work");

    // no store traffic while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_ctl.wr_en && !ram_ctl.rd_en)
        else $error("cell store accessed while idle");

    // scroll never reads row zero, so the destination row is always valid
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCR_RD || state_reg == S_SCR_WR |-> wk_row_reg != '0)
        else $error("scroll walk reached row zero");

    // after a character the cursor sits inside the visible area
    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && kind_reg == K_CHAR |-> cur_row_reg < rows && cur_col_reg < cols)
        else $error("cursor left the visible area");

endmodule

/* rtl/core/text_console_cursor_scroll_top.sv */
// top level of the text console engine: config registers, geometry, store, sequencer
`timescale 1ns / 1ps

// Text console with a cursor. Items enter on in_valid/in_ready with kind,
// char_code, read_row, read_col and end_of_write; each item yields exactly one
// result item on out_valid/out_ready (cell_value, cursor_row, cursor_col,
// scrolled, write_done). Registers are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, unknown indexes are dropped.
// One item is in work at a time; one shared address unit and a single port
// cell memory (one access per cycle) set the work done for each kind:
//   plain character          one cell write at the cursor
//   newline without scroll   cursor move only, no store access
//   scroll                   rows 1 to rows-1 copied one row up (read then write per cell)
//   clear                    rows*cols cells blanked (one cell per cycle)
//   read                     registered memory read; no store access outside the store
//   unused kind              no store access
// After reset the store is swept to zero, all MAX_ROWS*MAX_COLS cells (2000 at
// the defaults), during which in_ready stays low; config writes are taken.
// A finished result sits in the output register; the next item is accepted
// while it waits, and that item's result is held back until out_ready.
module text_console_cursor_scroll_top
    import tccs_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [ROW_W-1:0]      read_row,
    input  logic [COL_W-1:0]      read_col,
    input  logic                  end_of_write,
    // result items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CELL_W-1:0]     cell_value,
    output logic [ROW_W-1:0]      cursor_row,
    output logic [COL_W-1:0]      cursor_col,
    output logic                  scrolled,
    output logic                  write_done
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ROW_W-1:0]  rows_in_use_reg, rows_in_use_next;
    logic [COL_W-1:0]  cols_in_use_reg, cols_in_use_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;

    tccs_geom_t        geom;
    tccs_ram_ctl_t     ram_ctl;
    logic [AW-1:0]     ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    // register writes, each field masked to its width
    always_comb
    begin
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;
        attr_next        = attr_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS: rows_in_use_next = cfg_data[ROW_W-1:0];
                CFG_COLS: cols_in_use_next = cfg_data[COL_W-1:0];
                CFG_ATTR: attr_next        = cfg_data[ATTR_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= RST_ROWS;
            cols_in_use_reg <= RST_COLS;
            attr_reg        <= RST_ATTR;
        end
        else
        begin
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
            attr_reg        <= attr_next;
        end
    end

    // effective geometry: zero acts as one, anything past the store saturates
    always_comb
    begin
        geom.attr = attr_reg;
        if (rows_in_use_reg == '0)
        begin
            geom.rows = ROW_W'(1);
        end
        else if (32'(rows_in_use_reg) > 32'(MAX_ROWS))
        begin
            geom.rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            geom.rows = rows_in_use_reg;
        end
        if (cols_in_use_reg == '0)
        begin
            geom.cols = COL_W'(1);
        end
        else if (32'(cols_in_use_reg) > 32'(MAX_COLS))
        begin
            geom.cols = COL_W'(MAX_COLS);
        end
        else
        begin
            geom.cols = cols_in_use_reg;
        end
    end

    tccs_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    tccs_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .read_row     (read_row),
        .read_col     (read_col),
        .end_of_write (end_of_write),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_value   (cell_value),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .scrolled     (scrolled),
        .write_done   (write_done),
        .ram_ctl      (ram_ctl),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata)
    );

endmodule
